[rtl/dstt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline-sorted task table - shared types and constants
// Transfer payloads, stored entry layout, status and action codes, sequencer
// states.
// ----------------------------------------------------------------------------
package dstt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_AT_HEAD   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_ON_TIME   = 3'd3;
    localparam logic [2:0] ST_OVERDUE   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic        action;
        logic [31:0] task_ident;
        logic [31:0] abs_deadline;
        logic [31:0] done_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        head_valid;
        logic [31:0] head_task;
        logic [31:0] head_deadline;
        logic [4:0]  entry_count;
        logic [31:0] completed_count;
        logic [31:0] overdue_count;
    } t_out_item;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] task_id;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_REMOVE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/dstt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dstt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[rtl/deadline_sorted_task_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// Operation: an insert walks backward from the end of the table to its slot; a
//   rejected insert on a full table goes straight to its result; a remove walks the
//   whole table. A new item is taken only once the last result is in the output register.
// The single RAM read port walks one entry a cycle.
// Reset: synchronous, active low; the table empties and both counters clear at once,
//   the entry RAM is not cleared.
// ----------------------------------------------------------------------------
// Deadline-sorted task table
// Keeps active tasks sorted by absolute deadline in a RAM, inserting by a
// backward shift walk and removing by a forward search-and-compact walk.
// ----------------------------------------------------------------------------
module deadline_sorted_task_table
    import dstt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state       r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic         r_found, n_found;
    logic [31:0]  r_ident, n_ident;
    logic [31:0]  r_arg, n_arg;
    logic [31:0]  r_rem_dl, n_rem_dl;
    logic [2:0]   r_status, n_status;
    t_entry       r_head, n_head;
    logic [31:0]  r_done_cnt, n_done_cnt;
    logic [31:0]  r_late_cnt, n_late_cnt;
    logic         r_out_valid, n_out_valid;
    t_out_item    r_out, n_out;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    logic [CW-1:0] w_rd_idx;
    t_entry        w_rd_entry;
    logic          w_in_xfer;
    logic          w_out_free;
    logic [31:0]   w_cnt32;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_cnt32    = 32'(r_count);

    dstt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_idx[AW-1:0]),
        .o_rd_data (w_rd_entry)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.action == ACT_REMOVE) begin
                        n_state = S_REMOVE;
                    end else if (r_count >= CW'(TABLE_DEPTH)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_INSERT;
                    end
                end
            end
            S_INSERT: begin
                if (r_idx == '0 || w_rd_entry.deadline < r_arg) begin
                    n_state = S_DONE;
                end
            end
            S_REMOVE: begin
                if (r_idx == r_count) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_idx       = r_idx;
        n_count     = r_count;
        n_found     = r_found;
        n_ident     = r_ident;
        n_arg       = r_arg;
        n_rem_dl    = r_rem_dl;
        n_status    = r_status;
        n_head      = r_head;
        n_done_cnt  = r_done_cnt;
        n_late_cnt  = r_late_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx[AW-1:0];
        w_wr_data   = w_rd_entry;
        w_rd_idx    = r_idx + CW'(1);
        o_in_ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_data.action == ACT_INSERT) begin
                    // Prime the read of the last entry for the backward walk
                    w_rd_idx = r_count - CW'(1);
                end else begin
                    w_rd_idx = '0;
                end
                if (w_in_xfer) begin
                    n_found  = 1'b0;
                    n_ident  = i_in_data.task_ident;
                    n_status = ST_FULL;
                    if (i_in_data.action == ACT_INSERT) begin
                        n_idx = r_count;
                        n_arg = i_in_data.abs_deadline;
                    end else begin
                        n_idx = '0;
                        n_arg = i_in_data.done_ms;
                    end
                end
            end
            S_INSERT: begin
                w_rd_idx = r_idx - CW'(2);
                w_wr_en  = 1'b1;
                if (r_idx == '0 || w_rd_entry.deadline < r_arg) begin
                    w_wr_data = '{deadline: r_arg, task_id: r_ident};
                    n_count   = r_count + CW'(1);
                    if (r_idx == '0) begin
                        n_head   = '{deadline: r_arg, task_id: r_ident};
                        n_status = ST_AT_HEAD;
                    end else begin
                        n_status = ST_INSERTED;
                    end
                end else begin
                    // Shift the later-deadline entry up one slot
                    n_idx = r_idx - CW'(1);
                end
            end
            S_REMOVE: begin
                if (r_idx == r_count) begin
                    if (!r_found) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        n_count = r_count - CW'(1);
                        if (r_arg > r_rem_dl) begin
                            n_status   = ST_OVERDUE;
                            n_late_cnt = (r_late_cnt == '1) ? r_late_cnt
                                                            : r_late_cnt + 32'd1;
                        end else begin
                            n_status   = ST_ON_TIME;
                            n_done_cnt = (r_done_cnt == '1) ? r_done_cnt
                                                            : r_done_cnt + 32'd1;
                        end
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                    if (r_found) begin
                        // Compact: move each later entry down one slot
                        w_wr_en   = 1'b1;
                        w_wr_addr = AW'(r_idx - CW'(1));
                        if (r_idx == CW'(1)) begin
                            n_head = w_rd_entry;
                        end
                    end else if (w_rd_entry.task_id == r_ident) begin
                        n_found  = 1'b1;
                        n_rem_dl = w_rd_entry.deadline;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = r_status;
                    n_out.head_valid      = (r_count != '0);
                    n_out.head_task       = (r_count != '0) ? r_head.task_id : 32'd0;
                    n_out.head_deadline   = (r_count != '0) ? r_head.deadline : 32'd0;
                    n_out.entry_count     = w_cnt32[4:0];
                    n_out.completed_count = r_done_cnt;
                    n_out.overdue_count   = r_late_cnt;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_done_cnt  <= '0;
            r_late_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_done_cnt  <= n_done_cnt;
            r_late_cnt  <= n_late_cnt;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_ident  <= n_ident;
        r_arg    <= n_arg;
        r_rem_dl <= n_rem_dl;
        r_status <= n_status;
        r_head   <= n_head;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_wr_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_INSERT || r_state == S_REMOVE))
        else $error("RAM write outside a table walk");

    a_ins_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |-> (r_idx <= r_count && r_count < CW'(TABLE_DEPTH)))
        else $error("insert slot outside the occupied range");

    a_ins_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in_data.action == ACT_INSERT)
            |=> (r_state == S_INSERT || r_state == S_DONE))
        else $error("insert transfer did not start a walk or finish");

endmodule

`default_nettype wire
